// ----- rtl/rfd_pkg.sv -----
// Shared types, widths and helper functions for the RGB frame difference block.
// No dependencies; used by rgb_frame_difference_sad.
package rfd_pkg;

    // Field widths
    localparam int DATA_W        = 8;
    localparam int WORD_W        = 3 * DATA_W;
    localparam int SHIFT_W       = 5;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int IN_TDATA_W    = 6 * DATA_W;
    localparam int FRAME_SGN_W   = 35;
    localparam int FRAME_ABS_W   = 34;
    localparam int PIX_CNT_W     = 25;
    localparam int TOTAL_W       = 64;
    localparam int TOTAL_ABS_W   = 63;
    localparam int OUT_FIELDS_W  = WORD_W + FRAME_SGN_W + FRAME_ABS_W + PIX_CNT_W
                                   + TOTAL_W + TOTAL_ABS_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Per-pixel sums over three channels
    localparam int DIFF_W        = DATA_W + 1;
    localparam int PIX_SGN_W     = DIFF_W + 2;
    localparam int PIX_ABS_W     = DATA_W + 2;

    // Frame length where the frame sums stop growing
    localparam logic [PIX_CNT_W-1:0] MAX_FRAME_PIXELS = PIX_CNT_W'(16777216);

    // Register reset values
    localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = SHIFT_W'(16);
    localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = SHIFT_W'(8);
    localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = SHIFT_W'(0);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RED_SHIFT   = 2'd0,
        CFG_GREEN_SHIFT = 2'd1,
        CFG_BLUE_SHIFT  = 2'd2,
        CFG_MSB_FIRST   = 2'd3
    } cfg_idx_t;

    // One pixel pair after the input stage
    typedef struct packed {
        logic [WORD_W-1:0]           bytes;
        logic signed [PIX_SGN_W-1:0] sgn;
        logic [PIX_ABS_W-1:0]        mag;
        logic                        last;
    } pix_t;

    // Channel difference A - B
    function automatic logic signed [DIFF_W-1:0] chan_diff(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Magnitude of a channel difference
    function automatic logic [DATA_W-1:0] chan_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] neg;
        neg = -d;
        return d[DIFF_W-1] ? neg[DATA_W-1:0] : d[DATA_W-1:0];
    endfunction

    // Difference plus mid-scale, clamped, placed at its bit position in the word
    function automatic logic [WORD_W-1:0] chan_place(
        input logic signed [DIFF_W-1:0] d,
        input logic [SHIFT_W-1:0]       sh
    );
        logic [DATA_W-1:0]                v;
        logic [DATA_W+(1<<SHIFT_W)-2:0]   wide;
        if (d > $signed(DIFF_W'(127)))
            v = {DATA_W{1'b1}};
        else if (d < -$signed(DIFF_W'(128)))
            v = '0;
        else
            v = {~d[DATA_W-1], d[DATA_W-2:0]};
        wide = {{((1<<SHIFT_W)-1){1'b0}}, v} << sh;
        return wide[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/rgb_frame_difference_sad.sv -----
// RGB frame difference with per-frame and running sums of differences.
// Depends on rfd_pkg.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tdata: pixel pair, tlast: last of frame
//  m_*       out        m_tvalid/m_tready   tdata: bytes and sums, tlast: frame end
//  cfg_*     in         cfg_we              cfg_addr: register index, cfg_data: value
//
// One pixel pair per clock while m_* is not stalled; a result passes stage 1, then the output register.
// The accumulator update adds into the 35-bit, 34-bit and 25-bit frame state and the 64-bit totals.
// Reset clears the configuration to its defaults and all sums and counters to zero.
// A stall on m_* fills the input register and then drops s_tready; nothing is lost.
module rgb_frame_difference_sad
(
    input  logic                                clk,
    input  logic                                rst_n,
    // a_red, a_green, a_blue, b_red, b_green, b_blue (8 bits each, from bit 0 up)
    input  logic [rfd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // out_byte0, out_byte1, out_byte2, frame_signed_sum, frame_abs_sum, frame_pixels,
    // total_signed_sum, total_abs_sum, zero fill (from bit 0 up)
    output logic [rfd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DW = rfd_pkg::DATA_W;
    localparam int WW = rfd_pkg::WORD_W;
    localparam int SW = rfd_pkg::PIX_SGN_W;
    localparam int AW = rfd_pkg::PIX_ABS_W;
    localparam int FSW = rfd_pkg::FRAME_SGN_W;
    localparam int FAW = rfd_pkg::FRAME_ABS_W;
    localparam int CW = rfd_pkg::PIX_CNT_W;
    localparam int TW = rfd_pkg::TOTAL_W;

    // Configuration registers
    logic [rfd_pkg::SHIFT_W-1:0] red_shift_reg;
    logic [rfd_pkg::SHIFT_W-1:0] green_shift_reg;
    logic [rfd_pkg::SHIFT_W-1:0] blue_shift_reg;
    logic                        msb_first_reg;

    // Input stage
    logic                  s1_valid_reg;
    rfd_pkg::pix_t         s1_reg;
    rfd_pkg::pix_t         s1_next;

    // Accumulators
    logic signed [FSW-1:0] fsgn_reg;
    logic signed [FSW-1:0] fsgn_next;
    logic [FAW-1:0]        fabs_reg;
    logic [FAW-1:0]        fabs_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [TW-1:0]         gsgn_reg;
    logic [TW-1:0]         gsgn_next;
    logic [TW-1:0]         gabs_reg;
    logic [TW-1:0]         gabs_next;

    // Output register
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [WW-1:0]         out_bytes_reg;
    logic [FSW-1:0]        out_fsgn_reg;
    logic [FAW-1:0]        out_fabs_reg;
    logic [CW-1:0]         out_cnt_reg;

    logic                  in_take;
    logic                  s1_adv;

    logic signed [rfd_pkg::DIFF_W-1:0] d_r, d_g, d_b;
    logic [WW-1:0]         word;
    logic                  in_range;
    logic signed [FSW-1:0] fsgn_upd;
    logic [FAW-1:0]        fabs_upd;
    logic [CW-1:0]         cnt_upd;

    // Handshake: stage 1 moves on when the output register is empty or being drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_take  = s_tvalid && s_tready;

    // Channel differences, clamped values and byte order
    always_comb
    begin
        d_r  = rfd_pkg::chan_diff(s_tdata[0*DW +: DW], s_tdata[3*DW +: DW]);
        d_g  = rfd_pkg::chan_diff(s_tdata[1*DW +: DW], s_tdata[4*DW +: DW]);
        d_b  = rfd_pkg::chan_diff(s_tdata[2*DW +: DW], s_tdata[5*DW +: DW]);
        word = rfd_pkg::chan_place(d_r, red_shift_reg)
             | rfd_pkg::chan_place(d_g, green_shift_reg)
             | rfd_pkg::chan_place(d_b, blue_shift_reg);
        s1_next.bytes = msb_first_reg ? {word[7:0], word[15:8], word[23:16]} : word;
        s1_next.sgn   = SW'(d_r) + SW'(d_g) + SW'(d_b);
        s1_next.mag   = AW'(rfd_pkg::chan_mag(d_r)) + AW'(rfd_pkg::chan_mag(d_g))
                      + AW'(rfd_pkg::chan_mag(d_b));
        s1_next.last  = s_tlast;
    end

    // Frame sums with saturation on frame length, totals on end of frame
    always_comb
    begin
        in_range = cnt_reg < rfd_pkg::MAX_FRAME_PIXELS;
        fsgn_upd = fsgn_reg;
        fabs_upd = fabs_reg;
        cnt_upd  = cnt_reg;
        if (in_range)
        begin
            fsgn_upd = fsgn_reg + FSW'($signed(s1_reg.sgn));
            fabs_upd = fabs_reg + FAW'(s1_reg.mag);
            cnt_upd  = cnt_reg + CW'(1);
        end
        fsgn_next = fsgn_upd;
        fabs_next = fabs_upd;
        cnt_next  = cnt_upd;
        gsgn_next = gsgn_reg;
        gabs_next = gabs_reg;
        if (s1_reg.last)
        begin
            gsgn_next = gsgn_reg + TW'(fsgn_upd);
            gabs_next = gabs_reg + TW'(fabs_upd);
            fsgn_next = '0;
            fabs_next = '0;
            cnt_next  = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_shift_reg   <= rfd_pkg::RED_SHIFT_RST;
            green_shift_reg <= rfd_pkg::GREEN_SHIFT_RST;
            blue_shift_reg  <= rfd_pkg::BLUE_SHIFT_RST;
            msb_first_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (rfd_pkg::cfg_idx_t'(cfg_addr))
                rfd_pkg::CFG_RED_SHIFT:   red_shift_reg   <= cfg_data;
                rfd_pkg::CFG_GREEN_SHIFT: green_shift_reg <= cfg_data;
                rfd_pkg::CFG_BLUE_SHIFT:  blue_shift_reg  <= cfg_data;
                rfd_pkg::CFG_MSB_FIRST:   msb_first_reg   <= cfg_data[0];
                default:                  msb_first_reg   <= msb_first_reg;
            endcase
        end
    end

    // Control state: valid flags and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fsgn_reg      <= '0;
            fabs_reg      <= '0;
            cnt_reg       <= '0;
            gsgn_reg      <= '0;
            gabs_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                fsgn_reg <= fsgn_next;
                fabs_reg <= fabs_next;
                cnt_reg  <= cnt_next;
                gsgn_reg <= gsgn_next;
                gabs_reg <= gabs_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_reg <= s1_next;
        if (s1_adv)
        begin
            out_last_reg  <= s1_reg.last;
            out_bytes_reg <= s1_reg.bytes;
            out_fsgn_reg  <= s1_reg.last ? fsgn_upd : '0;
            out_fabs_reg  <= s1_reg.last ? fabs_upd : '0;
            out_cnt_reg   <= s1_reg.last ? cnt_upd  : '0;
        end
    end

    // Totals are read straight from the accumulators; they hold while a result waits
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{rfd_pkg::OUT_PAD_W{1'b0}},
                       gabs_reg[rfd_pkg::TOTAL_ABS_W-1:0],
                       gsgn_reg,
                       out_cnt_reg,
                       out_fabs_reg,
                       out_fsgn_reg,
                       out_bytes_reg};

    // Frame length never passes the saturation point
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rfd_pkg::MAX_FRAME_PIXELS)
        else $error("pixel counter above frame limit");

    // Frame statistics are zero on results that do not end a frame
    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[117:24] == '0))
        else $error("frame statistics on a mid-frame result");

    // Sums restart after a frame end moves to the output
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.last) |=> (cnt_reg == '0 && fsgn_reg == '0 && fabs_reg == '0))
        else $error("frame sums not cleared at frame end");

    // Input stalls only while stage 1 holds a request
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked pipeline");

endmodule
